// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define MLBT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define MLBT_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/mlbt_pkg.sv =====
package mlbt_pkg;

    localparam int LED_COUNT = 4;
    localparam int TIME_BITS = 24;
    localparam int FIELD_TIME_W = 24;
    localparam int INDEX_W = 3;
    localparam int PIN_W = 4;
    localparam int OFF_RESET = 255;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    typedef enum logic
    {
        MODE_TICK = 1'b0,
        MODE_SET  = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic tick;
        logic set;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/mlbt_led_cell.sv =====
`include "assert_macros.svh"

module mlbt_led_cell #(
    parameter int TIME_BITS = mlbt_pkg::TIME_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mlbt_pkg::cell_ctrl_t ctrl,
    input  logic [TIME_BITS-1:0] on_time,
    input  logic [TIME_BITS-1:0] off_time,
    output logic                 lit_next
);

    localparam logic [TIME_BITS-1:0] One = TIME_BITS'(1);
    localparam logic [TIME_BITS-1:0] OffReset = TIME_BITS'(mlbt_pkg::OFF_RESET);

    logic [TIME_BITS-1:0] on_ticks_reg;
    logic [TIME_BITS-1:0] on_ticks_next;
    logic [TIME_BITS-1:0] off_ticks_reg;
    logic [TIME_BITS-1:0] off_ticks_next;
    logic [TIME_BITS-1:0] remaining_reg;
    logic [TIME_BITS-1:0] remaining_next;
    logic                 lit_reg;
    logic                 pending_reg;
    logic                 pending_next;

    always_comb
    begin
        logic [TIME_BITS-1:0] r;
        logic                 p;
        logic                 l;
        on_ticks_next  = on_ticks_reg;
        off_ticks_next = off_ticks_reg;
        r = remaining_reg;
        p = pending_reg;
        l = lit_reg;
        if (ctrl.set)
        begin
            on_ticks_next  = on_time;
            off_ticks_next = off_time;
            p = 1'b1;
        end
        else if (ctrl.tick)
        begin
            // reload phase
            if (p && l && (off_ticks_reg != '0))
            begin
                l = 1'b0;
                r = off_ticks_reg;
                p = 1'b0;
            end
            else if (p && !l && (on_ticks_reg != '0))
            begin
                l = 1'b1;
                r = on_ticks_reg;
                p = 1'b0;
            end
            // count phase
            if (r > One)
            begin
                r = r - One;
            end
            else if (r == One)
            begin
                p = 1'b1;
            end
        end
        remaining_next = r;
        pending_next   = p;
        lit_next       = l;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg  <= '0;
            off_ticks_reg <= OffReset;
            remaining_reg <= '0;
            lit_reg       <= 1'b0;
            pending_reg   <= 1'b1;
        end
        else
        begin
            on_ticks_reg  <= on_ticks_next;
            off_ticks_reg <= off_ticks_next;
            remaining_reg <= remaining_next;
            lit_reg       <= lit_next;
            pending_reg   <= pending_next;
        end
    end

    `MLBT_ASSERT(a_set_marks_pending, clk, rst_n, ctrl.set |=> pending_reg, "set did not mark pending")
    `MLBT_ASSERT(a_lit_only_on_tick, clk, rst_n, !ctrl.tick |=> $stable(lit_reg), "lit moved without tick")
    `MLBT_ASSERT(a_count_down, clk, rst_n, (ctrl.tick && !pending_reg && (remaining_reg > One)) |=> (remaining_reg == $past(remaining_reg) - One), "count did not decrement")
    `MLBT_ASSERT_NEVER(a_tick_and_set, clk, rst_n, ctrl.tick && ctrl.set, "tick and set together")

endmodule

// ===== hw/rtl/multi_led_blink_timer_top.sv =====
// path: input transfer into the input register, then result into the result register
// throughput: one item per cycle while m_tready holds; all leds update in parallel on a tick
// output register frees the input side while a result waits for m_tready
// reset: rst_n asynchronous active low; leds dark and pending, off times 255, mask 0
module multi_led_blink_timer_top #(
    parameter int LED_COUNT = mlbt_pkg::LED_COUNT,
    parameter int TIME_BITS = mlbt_pkg::TIME_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // led_index[2:0], on_time[26:3], off_time[50:27], zero pad
    input  logic [mlbt_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // led_pins[3:0], set_error[4], zero pad
    output logic [mlbt_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [mlbt_pkg::PIN_W-1:0]       cfg_wr_data
);

    localparam int FieldW = mlbt_pkg::FIELD_TIME_W;
    localparam int IdxW = mlbt_pkg::INDEX_W;
    localparam int PinW = mlbt_pkg::PIN_W;
    localparam int PadW = (LED_COUNT > PinW) ? LED_COUNT : PinW;
    localparam logic [TIME_BITS-1:0] TimeMax = '1;

    logic                 in_valid_reg;
    mlbt_pkg::mode_t      in_mode_reg;
    logic [IdxW-1:0]      in_idx_reg;
    logic [FieldW-1:0]    in_on_reg;
    logic [FieldW-1:0]    in_off_reg;
    logic                 out_valid_reg;
    logic [PinW-1:0]      out_pins_reg;
    logic                 out_err_reg;
    logic [PinW-1:0]      mask_reg;

    logic                 advance;
    logic                 idx_ok;
    logic [TIME_BITS-1:0] on_sat;
    logic [TIME_BITS-1:0] off_sat;
    logic [LED_COUNT-1:0] lit_next;
    logic [PadW-1:0]      lit_pad;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign idx_ok   = ({1'b0, in_idx_reg} < (IdxW + 1)'(LED_COUNT));

    // clamp incoming times to the counter width
    if (TIME_BITS >= FieldW)
    begin : g_time_wide
        assign on_sat  = TIME_BITS'(in_on_reg);
        assign off_sat = TIME_BITS'(in_off_reg);
    end
    else
    begin : g_time_sat
        assign on_sat  = (in_on_reg[FieldW-1:TIME_BITS] != '0) ? TimeMax
                                                               : in_on_reg[TIME_BITS-1:0];
        assign off_sat = (in_off_reg[FieldW-1:TIME_BITS] != '0) ? TimeMax
                                                                : in_off_reg[TIME_BITS-1:0];
    end

    for (genvar i = 0; i < LED_COUNT; i++)
    begin : g_led
        mlbt_pkg::cell_ctrl_t ctrl;

        assign ctrl.tick = advance && (in_mode_reg == mlbt_pkg::MODE_TICK);
        assign ctrl.set  = advance && (in_mode_reg == mlbt_pkg::MODE_SET)
                           && (in_idx_reg == IdxW'(i));

        mlbt_led_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .on_time  (on_sat),
            .off_time (off_sat),
            .lit_next (lit_next[i])
        );
    end

    assign lit_pad = PadW'(lit_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= mlbt_pkg::mode_t'(s_tuser);
            in_idx_reg  <= s_tdata[IdxW-1:0];
            in_on_reg   <= s_tdata[IdxW+FieldW-1:IdxW];
            in_off_reg  <= s_tdata[IdxW+2*FieldW-1:IdxW+FieldW];
        end
        if (advance)
        begin
            out_pins_reg <= lit_pad[PinW-1:0] ^ mask_reg;
            out_err_reg  <= (in_mode_reg == mlbt_pkg::MODE_SET) && !idx_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(mlbt_pkg::M_TDATA_W - PinW - 1)'(0), out_err_reg, out_pins_reg};

endmodule
